FILE: rtl/core/slrd_pkg.sv
// ----------------------------------------------------------------------------
// slrd_pkg
// shared types, record codes and field layout tables for the log deframer
// ----------------------------------------------------------------------------
`default_nettype none

package slrd_pkg;

  // record kinds, in the order they follow a header
  localparam logic [2:0] KIND_ROT      = 3'd0;
  localparam logic [2:0] KIND_ACCEL    = 3'd1;
  localparam logic [2:0] KIND_COMPASS  = 3'd2;
  localparam logic [2:0] KIND_GYRO     = 3'd3;
  localparam logic [2:0] KIND_PRESSURE = 3'd4;
  localparam logic [2:0] KIND_GPS      = 3'd5;
  localparam logic [2:0] KIND_NONE     = 3'd6;
  localparam int         NumKinds      = 6;

  // header flag bit positions
  localparam int HdrGpsBit      = 0;
  localparam int HdrRotBit      = 1;
  localparam int HdrRawBit      = 2;
  localparam int HdrAccelBit    = 3;
  localparam int HdrCompassBit  = 4;
  localparam int HdrGyroBit     = 5;
  localparam int HdrPressureBit = 6;

  localparam int AccBytes = 7;

  typedef struct packed {
    logic                  in_frame;
    logic [NumKinds-1:0]   sel;
    logic [2:0]            kind;
    logic [3:0]            field;
    logic [2:0]            cnt;
    logic [8*AccBytes-1:0] acc;
  } slrd_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  index;
    logic [3:0]  nbytes;
    logic [63:0] value;
    logic        last_rec;
    logic        last_frame;
  } slrd_result_t;

  // selected kinds of a header byte
  function automatic logic [NumKinds-1:0] hdr_sel(input logic [7:0] hdr);
    logic [NumKinds-1:0] s;
    s = '0;
    s[KIND_ROT]      = hdr[HdrRotBit];
    s[KIND_ACCEL]    = hdr[HdrRawBit] & hdr[HdrAccelBit];
    s[KIND_COMPASS]  = hdr[HdrRawBit] & hdr[HdrCompassBit];
    s[KIND_GYRO]     = hdr[HdrRawBit] & hdr[HdrGyroBit];
    s[KIND_PRESSURE] = hdr[HdrRawBit] & hdr[HdrPressureBit];
    s[KIND_GPS]      = hdr[HdrGpsBit];
    return s;
  endfunction

  // first selected kind at or after from, KIND_NONE when there is none
  function automatic logic [2:0] next_kind(input logic [2:0] from,
                                           input logic [NumKinds-1:0] sel);
    logic [2:0] nk;
    logic       found;
    nk    = KIND_NONE;
    found = 1'b0;
    for (int k = 0; k < NumKinds; k++) begin
      if (!found && sel[k] && (3'(k) >= from)) begin
        nk    = 3'(k);
        found = 1'b1;
      end
    end
    return nk;
  endfunction

  function automatic logic [3:0] field_count(input logic [2:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_GPS: n = 4'd10;
      default:  n = 4'd5;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] field_size(input logic [2:0] kind,
                                            input logic [3:0] field);
    logic [3:0] s;
    s = 4'd0;
    case (kind)
      KIND_ROT: begin
        case (field)
          4'd0:    s = 4'd4;
          4'd4:    s = 4'd2;
          default: s = 4'd8;
        endcase
      end
      KIND_ACCEL, KIND_COMPASS, KIND_GYRO: begin
        case (field)
          4'd0:    s = 4'd4;
          default: s = 4'd2;
        endcase
      end
      KIND_PRESSURE: begin
        case (field)
          4'd0:    s = 4'd4;
          4'd1:    s = 4'd2;
          default: s = 4'd1;
        endcase
      end
      KIND_GPS: begin
        case (field)
          4'd1, 4'd5, 4'd6: s = 4'd1;
          default:          s = 4'd4;
        endcase
      end
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/slrd_step.sv
// ----------------------------------------------------------------------------
// slrd_step
// next-state and field result logic for one stream byte
// ----------------------------------------------------------------------------
`default_nettype none

module slrd_step (
  input  var slrd_pkg::slrd_state_t  st,
  input  wire logic [7:0]            data_byte,
  output var slrd_pkg::slrd_state_t  st_nxt,
  output logic                       emit,
  output var slrd_pkg::slrd_result_t res
);
  import slrd_pkg::*;

  logic [NumKinds-1:0] sel;
  logic [2:0]          nk_hdr;
  logic [2:0]          nk_rec;
  logic [3:0]          size;
  logic [3:0]          count;
  logic [63:0]         value;
  logic                last_rec;
  logic                done;

  assign sel    = hdr_sel(data_byte);
  assign nk_hdr = next_kind(3'd0, sel);
  assign size   = field_size(st.kind, st.field);
  assign count  = field_count(st.kind);
  assign value  = {8'd0, st.acc} | ({56'd0, data_byte} << {st.cnt, 3'b000});
  assign done   = ({1'b0, st.cnt} + 4'd1) >= size;
  assign last_rec = ({1'b0, st.field} + 5'd1) >= {1'b0, count};
  assign nk_rec = next_kind(st.kind + 3'd1, st.sel);

  always_comb begin
    st_nxt         = st;
    emit           = 1'b0;
    res.kind       = st.kind;
    res.index      = st.field;
    res.nbytes     = size;
    res.value      = value;
    res.last_rec   = last_rec;
    res.last_frame = last_rec && (nk_rec == KIND_NONE);
    if (!st.in_frame) begin
      // header byte, dropped when it selects nothing
      if (nk_hdr != KIND_NONE) begin
        st_nxt.in_frame = 1'b1;
        st_nxt.sel      = sel;
        st_nxt.kind     = nk_hdr;
        st_nxt.field    = 4'd0;
        st_nxt.cnt      = 3'd0;
        st_nxt.acc      = '0;
      end
    end else if ((st.kind >= KIND_NONE) || (st.field >= count)) begin
      // broken state, close the frame
      st_nxt = '0;
    end else if (!done) begin
      st_nxt.cnt = st.cnt + 3'd1;
      st_nxt.acc = value[8*AccBytes-1:0];
    end else begin
      emit       = 1'b1;
      st_nxt.cnt = 3'd0;
      st_nxt.acc = '0;
      if (res.last_frame) begin
        st_nxt = '0;
      end else if (last_rec) begin
        st_nxt.kind  = nk_rec;
        st_nxt.field = 4'd0;
      end else begin
        st_nxt.field = st.field + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sensor_log_record_deframer_core.sv
// pipeline: a byte is registered on accept and its field result, if any, is
//   registered in the result register when the byte leaves the input register
// throughput: one byte per clock, unless a byte with a result waits on a held
//   output; the field step between input and result register is combinational
// reset: synchronous active-low rst_n; the block waits for a header byte after it
// ----------------------------------------------------------------------------
// sensor_log_record_deframer_core
// splits a byte-wide sensor log into little-endian fields, one request per field
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_log_record_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  // field results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_record_kind,
  output logic [3:0]       out_field_index,
  output logic [3:0]       out_field_bytes,
  output logic [63:0]      out_field_value,
  output logic             out_last_of_record,
  output logic             out_last_of_frame
);
  import slrd_pkg::*;

  // input register, also serves as the skid stage while the output is held
  logic         byte_vld_r;
  logic         byte_vld_nxt;
  logic [7:0]   byte_r;

  // parse state
  slrd_state_t  st_r;
  slrd_state_t  st_nxt;
  slrd_result_t res;
  logic         emit;

  // result register
  logic         out_vld_r;
  logic         out_vld_nxt;
  slrd_result_t out_r;

  logic         out_free;
  logic         advance;
  logic         in_take;

  slrd_step u_step (
    .st        (st_r),
    .data_byte (byte_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .res       (res)
  );

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_vld_r || !out_stall;
  // a byte that yields no result may move on even while the output is held
  assign advance  = byte_vld_r && (out_free || !emit);
  assign in_stall = byte_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (advance) begin
      byte_vld_nxt = 1'b0;
    end
    if (in_take) begin
      byte_vld_nxt = 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_free) begin
      out_vld_nxt = advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r       <= '0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_data_byte;
    end
    if (advance && emit) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_record_kind    = out_r.kind;
  assign out_field_index    = out_r.index;
  assign out_field_bytes    = out_r.nbytes;
  assign out_field_value    = out_r.value;
  assign out_last_of_record = out_r.last_rec;
  assign out_last_of_frame  = out_r.last_frame;

  // no partial field is pending outside a frame
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.in_frame |-> (st_r.cnt == 3'd0))
    else $error("byte count nonzero outside a frame");

  // the frame closes right after its last field
  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit && res.last_frame) |=> !st_r.in_frame)
    else $error("frame still open after its last field");

  // a frame end is always a record end
  a_frame_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (!out_r.last_frame || out_r.last_rec))
    else $error("frame end without record end");

  // result field sizes stay within one to eight bytes
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((out_r.nbytes != 4'd0) && (out_r.nbytes <= 4'd8)))
    else $error("bad field size on result");

  // an open frame always points at a real record kind
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.in_frame |-> (st_r.kind <= KIND_GPS))
    else $error("open frame with bad record kind");

endmodule

`default_nettype wire

FILE: sim/tb_sensor_log_record_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_sensor_log_record_deframer_core
// self-checking bench: feeds header and field bytes through the valid/stall
// byte port, predicts every completed field in a scoreboard that tracks the
// frame state, and compares each field request that leaves the block
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sensor_log_record_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import slrd_pkg::*;

  // field predictor and store of expected field requests
  class field_scoreboard;
    bit           in_frame;
    logic [7:0]   hdr;
    logic [2:0]   kind;
    logic [3:0]   field;
    int unsigned  nbytes_got;
    logic [63:0]  acc;
    slrd_result_t pending_fields[$];
    int           errors;

    function new();
      in_frame   = 1'b0;
      hdr        = '0;
      kind       = KIND_ROT;
      field      = '0;
      nbytes_got = 0;
      acc        = '0;
      errors     = 0;
    endfunction

    // raw sub-records only count when the raw bit is set as well
    function bit kind_on(int k, logic [7:0] h);
      bit on;
      case (k)
        KIND_ROT:      on = h[HdrRotBit];
        KIND_ACCEL:    on = h[HdrRawBit] && h[HdrAccelBit];
        KIND_COMPASS:  on = h[HdrRawBit] && h[HdrCompassBit];
        KIND_GYRO:     on = h[HdrRawBit] && h[HdrGyroBit];
        KIND_PRESSURE: on = h[HdrRawBit] && h[HdrPressureBit];
        KIND_GPS:      on = h[HdrGpsBit];
        default:       on = 1'b0;
      endcase
      return on;
    endfunction

    function logic [2:0] first_kind(int from, logic [7:0] h);
      for (int k = from; k < NumKinds; k++) begin
        if (kind_on(k, h)) return 3'(k);
      end
      return KIND_NONE;
    endfunction

    function int unsigned fields_in(logic [2:0] k);
      return (k == KIND_GPS) ? 10 : 5;
    endfunction

    function int unsigned bytes_of(logic [2:0] k, logic [3:0] f);
      int unsigned sz[10];
      case (k)
        KIND_ROT:      sz = '{4, 8, 8, 8, 2, 0, 0, 0, 0, 0};
        KIND_PRESSURE: sz = '{4, 2, 1, 1, 1, 0, 0, 0, 0, 0};
        KIND_GPS:      sz = '{4, 1, 4, 4, 4, 1, 1, 4, 4, 4};
        default:       sz = '{4, 2, 2, 2, 2, 0, 0, 0, 0, 0};
      endcase
      return sz[f];
    endfunction

    // called for every accepted byte request
    function void note_byte(logic [7:0] b);
      logic [2:0]   nk;
      bit           last_rec;
      slrd_result_t r;
      if (!in_frame) begin
        nk = first_kind(0, b);
        if (nk == KIND_NONE) return;
        hdr        = b;
        kind       = nk;
        field      = '0;
        nbytes_got = 0;
        acc        = '0;
        in_frame   = 1'b1;
        return;
      end
      acc = acc | (64'(b) << (8 * nbytes_got));
      if (nbytes_got + 1 < bytes_of(kind, field)) begin
        nbytes_got++;
        return;
      end
      last_rec     = (field + 1) >= fields_in(kind);
      nk           = last_rec ? first_kind(kind + 1, hdr) : kind;
      r.kind       = kind;
      r.index      = field;
      r.nbytes     = 4'(bytes_of(kind, field));
      r.value      = acc;
      r.last_rec   = last_rec;
      r.last_frame = last_rec && (nk == KIND_NONE);
      pending_fields.push_back(r);
      nbytes_got = 0;
      acc        = '0;
      if (r.last_frame) begin
        in_frame = 1'b0;
        hdr      = '0;
        kind     = KIND_ROT;
        field    = '0;
      end else if (last_rec) begin
        kind  = nk;
        field = '0;
      end else begin
        field = field + 4'd1;
      end
    endfunction

    // called for every accepted field request
    function void check_field(slrd_result_t act);
      slrd_result_t exp;
      if (pending_fields.size() == 0) begin
        $error("unexpected field request: kind %0d index %0d value %h",
               act.kind, act.index, act.value);
        errors++;
        return;
      end
      exp = pending_fields.pop_front();
      if (act.kind !== exp.kind) begin
        $error("record_kind: expected %0d, got %0d", exp.kind, act.kind);
        errors++;
      end
      if (act.index !== exp.index) begin
        $error("field_index: expected %0d, got %0d", exp.index, act.index);
        errors++;
      end
      if (act.nbytes !== exp.nbytes) begin
        $error("field_bytes: expected %0d, got %0d", exp.nbytes, act.nbytes);
        errors++;
      end
      if (act.value !== exp.value) begin
        $error("field_value: expected %h, got %h", exp.value, act.value);
        errors++;
      end
      if (act.last_rec !== exp.last_rec) begin
        $error("last_of_record: expected %0b, got %0b", exp.last_rec, act.last_rec);
        errors++;
      end
      if (act.last_frame !== exp.last_frame) begin
        $error("last_of_frame: expected %0b, got %0b", exp.last_frame, act.last_frame);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_record_kind;
  logic [3:0]  out_field_index;
  logic [3:0]  out_field_bytes;
  logic [63:0] out_field_value;
  logic        out_last_of_record;
  logic        out_last_of_frame;

  field_scoreboard sb;
  int unsigned     bytes_offered;
  int unsigned     fields_seen;

  sensor_log_record_deframer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_record_kind   (out_record_kind),
    .out_field_index   (out_field_index),
    .out_field_bytes   (out_field_bytes),
    .out_field_value   (out_field_value),
    .out_last_of_record(out_last_of_record),
    .out_last_of_frame (out_last_of_frame)
  );

  always #5 clk = ~clk;

  // offer one byte request, with a random gap in front of it, and wait for
  // it to be taken; every fourth block of 64 bytes goes back to back
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (((bytes_offered / 64) % 4) == 3) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    // signals sampled at the edge still hold their pre-edge values
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_offered++;
  endtask

  // field requests leaving the block go straight to the scoreboard
  always @(posedge clk) begin
    slrd_result_t act;
    if (rst_n && out_valid && !out_stall) begin
      act.kind       = out_record_kind;
      act.index      = out_field_index;
      act.nbytes     = out_field_bytes;
      act.value      = out_field_value;
      act.last_rec   = out_last_of_record;
      act.last_frame = out_last_of_frame;
      sb.check_field(act);
      fields_seen++;
    end
  end

  // receiver: random stall ahead of each field request, bursts without
  // stall, and one long hold-off so the byte side backs up
  initial begin
    int unsigned n;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      n = (((fields_seen / 48) % 4) == 2) ? 0 : $urandom_range(0, 11);
      if (!long_hold_done && fields_seen >= 60) begin
        n              = 400;
        long_hold_done = 1'b1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // stimulus
  initial begin
    // empty headers, then a pressure frame with bit 7 set and an accel frame
    logic [7:0]  opening_stream [27] = '{
      8'h00, 8'h04, 8'h78, 8'h80,
      8'hC4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80,
      8'h0C, 8'h78, 8'h56, 8'h34, 8'h12, 8'h00, 8'h80, 8'hFF, 8'h7F,
      8'h01, 8'h00, 8'hAA, 8'h55
    };
    // one selected sub-record each
    logic [7:0]  single_kind_hdr [6] = '{8'h02, 8'h0C, 8'h14, 8'h24, 8'h44, 8'h01};
    logic [7:0]  hdr;
    logic [7:0]  data;
    int unsigned counted;

    sb            = new();
    bytes_offered = 0;
    fields_seen   = 0;
    counted       = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_stream[i]) send_byte(opening_stream[i]);

    // random frames: mostly live headers with random field contents,
    // some empty headers as noise
    while (counted < 950) begin
      case ($urandom_range(0, 9))
        6, 7:    hdr = single_kind_hdr[$urandom_range(0, 5)];
        8:       hdr = 8'($urandom_range(0, 255)) & 8'hF8;  // raw bit clear
        9:       hdr = 8'h04 | (8'($urandom_range(0, 255)) & 8'h80);  // raw alone
        default: hdr = 8'($urandom_range(0, 255));
      endcase
      send_byte(hdr);
      if (sb.in_frame) counted++;
      while (sb.in_frame) begin
        case ($urandom_range(0, 7))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom_range(0, 255));
        endcase
        send_byte(data);
        counted++;
      end
    end
    in_valid <= 1'b0;

    // drain, then give the two-stage pipe time to show anything extra
    while (sb.pending_fields.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_fields.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sensor_log_record_deframer_core.f
rtl/core/slrd_pkg.sv
rtl/core/slrd_step.sv
rtl/core/sensor_log_record_deframer_core.sv
sim/tb_sensor_log_record_deframer_core.sv
